// ===== hdl/tlsp_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the shortest-path engine.
`timescale 1ns / 1ps
package tlsp_pkg;

    localparam int DEF_MAX_NODES   = 256;
    localparam int DEF_MAX_EDGES   = 1024;
    localparam int DEF_HEAP_DEPTH  = 2048;
    localparam int DEF_WEIGHT_BITS = 20;

    localparam int DIST_W     = 40;
    localparam int NODE_FW    = 8;
    localparam int WEIGHT_FW  = 20;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int CMP_W      = 13;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 88;
    localparam int ST_W       = 5;
    localparam int RET_W      = 2;

    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MARK     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RUN      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_HEAP_OVF = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EDGE_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'd1;

    localparam logic [ST_W-1:0] ST_INIT  = 5'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 5'd1;
    localparam logic [ST_W-1:0] ST_DEC   = 5'd2;
    localparam logic [ST_W-1:0] ST_RDW   = 5'd3;
    localparam logic [ST_W-1:0] ST_CLR   = 5'd4;
    localparam logic [ST_W-1:0] ST_RCLR  = 5'd5;
    localparam logic [ST_W-1:0] ST_RSRD  = 5'd6;
    localparam logic [ST_W-1:0] ST_RSSET = 5'd7;
    localparam logic [ST_W-1:0] ST_PUS   = 5'd8;
    localparam logic [ST_W-1:0] ST_PUC   = 5'd9;
    localparam logic [ST_W-1:0] ST_PUF   = 5'd10;
    localparam logic [ST_W-1:0] ST_POPC  = 5'd11;
    localparam logic [ST_W-1:0] ST_POPT  = 5'd12;
    localparam logic [ST_W-1:0] ST_POPL  = 5'd13;
    localparam logic [ST_W-1:0] ST_SDS   = 5'd14;
    localparam logic [ST_W-1:0] ST_SDL   = 5'd15;
    localparam logic [ST_W-1:0] ST_SDR   = 5'd16;
    localparam logic [ST_W-1:0] ST_PROC  = 5'd17;
    localparam logic [ST_W-1:0] ST_PRCHK = 5'd18;
    localparam logic [ST_W-1:0] ST_EDGE  = 5'd19;
    localparam logic [ST_W-1:0] ST_EDCHK = 5'd20;
    localparam logic [ST_W-1:0] ST_RBRD  = 5'd21;
    localparam logic [ST_W-1:0] ST_RWRD  = 5'd22;
    localparam logic [ST_W-1:0] ST_RXC   = 5'd23;
    localparam logic [ST_W-1:0] ST_RESP  = 5'd24;

    localparam logic [RET_W-1:0] RET_POP  = 2'd0;
    localparam logic [RET_W-1:0] RET_RW   = 2'd1;
    localparam logic [RET_W-1:0] RET_EDGE = 2'd2;

    typedef struct packed {
        logic [ST_W-1:0] op;
        logic            load_in;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic a_ok;
        logic src_ok;
        logic sweep_last;
        logic heap_full;
        logic size_zero;
        logic size_one;
        logic pu_less;
        logic p_zero;
        logic l_in;
        logic r_in;
        logic sd_move;
        logic stale;
        logic k_done;
        logic edge_hit;
        logic boost;
        logic improve;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/tlsp_ctrl.sv =====
// Sequencer state machine of the shortest-path engine.
`timescale 1ns / 1ps
module tlsp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  tlsp_pkg::dp_status_t  stat,
    output tlsp_pkg::ctl_cmd_t    cmd
);
    import tlsp_pkg::*;

    logic [ST_W-1:0]  state_reg, state_next;
    logic [RET_W-1:0] ret_reg, ret_next;
    logic [ST_W-1:0]  ret_state;

    always_comb begin
        case (ret_reg)
            RET_POP:  ret_state = ST_POPC;
            RET_RW:   ret_state = ST_RWRD;
            RET_EDGE: ret_state = ST_EDGE;
            default:  ret_state = ST_POPC;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_INIT:  if (stat.sweep_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_DEC;
            ST_DEC: begin
                case (stat.in_cmd)
                    CMD_ADD_EDGE: state_next = ST_RESP;
                    CMD_MARK:     state_next = ST_RESP;
                    CMD_RUN:      state_next = ST_RCLR;
                    CMD_READ:     state_next = stat.a_ok ? ST_RDW : ST_RESP;
                    CMD_CLEAR:    state_next = ST_CLR;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_RDW:   state_next = ST_RESP;
            ST_CLR:   if (stat.sweep_last) state_next = ST_RESP;
            ST_RCLR: begin
                if (stat.sweep_last) state_next = stat.src_ok ? ST_RSRD : ST_RESP;
            end
            ST_RSRD:  state_next = ST_RSSET;
            ST_RSSET: begin
                ret_next   = RET_POP;
                state_next = ST_PUS;
            end
            ST_PUS: begin
                if (stat.heap_full || stat.size_zero) state_next = ret_state;
                else state_next = ST_PUC;
            end
            ST_PUC: begin
                if (stat.pu_less) state_next = stat.p_zero ? ST_PUF : ST_PUC;
                else state_next = ret_state;
            end
            ST_PUF:   state_next = ret_state;
            ST_POPC:  state_next = stat.size_zero ? ST_RESP : ST_POPT;
            ST_POPT:  state_next = stat.size_one ? ST_PROC : ST_POPL;
            ST_POPL:  state_next = ST_SDS;
            ST_SDS:   state_next = stat.l_in ? ST_SDL : ST_PROC;
            ST_SDL: begin
                if (stat.r_in) state_next = ST_SDR;
                else state_next = stat.sd_move ? ST_SDS : ST_PROC;
            end
            ST_SDR:   state_next = stat.sd_move ? ST_SDS : ST_PROC;
            ST_PROC:  state_next = ST_PRCHK;
            ST_PRCHK: state_next = stat.stale ? ST_POPC : ST_EDGE;
            ST_EDGE:  state_next = stat.k_done ? ST_POPC : ST_EDCHK;
            ST_EDCHK: begin
                if (!stat.edge_hit) state_next = ST_EDGE;
                else state_next = stat.boost ? ST_RBRD : ST_RWRD;
            end
            ST_RBRD: begin
                ret_next   = RET_RW;
                state_next = ST_RXC;
            end
            ST_RWRD: begin
                ret_next   = RET_EDGE;
                state_next = ST_RXC;
            end
            ST_RXC:   state_next = stat.improve ? ST_PUS : ret_state;
            ST_RESP:  if (stat.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            ret_reg   <= RET_POP;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.op      = state_reg;
    assign cmd.load_in = (state_reg == ST_IDLE) && s_tvalid;

endmodule

// ===== hdl/tlsp_dp.sv =====
// Datapath of the shortest-path engine: stores, heap, distance arithmetic and result register.
`timescale 1ns / 1ps
module tlsp_dp #(
    parameter int MAX_NODES   = tlsp_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES   = tlsp_pkg::DEF_MAX_EDGES,
    parameter int HEAP_DEPTH  = tlsp_pkg::DEF_HEAP_DEPTH,
    parameter int WEIGHT_BITS = tlsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tlsp_pkg::ctl_cmd_t                  cmd,
    output tlsp_pkg::dp_status_t                stat,
    input  logic [tlsp_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [tlsp_pkg::CMD_W-1:0]          s_tuser,
    input  logic                                cfg_wr_en,
    input  logic [tlsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tlsp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [tlsp_pkg::STATUS_W-1:0]       m_tuser
);
    import tlsp_pkg::*;

    localparam int NIW = $clog2(MAX_NODES);
    localparam int SW  = (WEIGHT_BITS < WEIGHT_FW) ? WEIGHT_BITS : WEIGHT_FW;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EW  = 2 * NODE_FW + SW;
    localparam int HAW = $clog2(HEAP_DEPTH);
    localparam int HSW = $clog2(HEAP_DEPTH + 1);
    localparam int HIW = HAW + 2;
    localparam int HEW = DIST_W + NIW + 1;
    localparam logic [DIST_W-1:0] INF = {DIST_W{1'b1}};

    logic [EW-1:0]     edge_mem [MAX_EDGES];
    logic [HEW-1:0]    heap_mem [HEAP_DEPTH];
    logic [DIST_W-1:0] dw_mem   [MAX_NODES];
    logic [DIST_W-1:0] db_mem   [MAX_NODES];
    logic              mark_mem [MAX_NODES];

    logic [EW-1:0]     edge_rdata_reg;
    logic [HEW-1:0]    heap_rdata_reg;
    logic [DIST_W-1:0] dw_rdata_reg, db_rdata_reg;
    logic              mark_rdata_reg;

    logic [CFG_DATA_W-1:0] node_count_reg;
    logic [NODE_FW-1:0]    source_reg;
    logic [CMD_W-1:0]      in_cmd_reg;
    logic [NODE_FW-1:0]    in_a_reg, in_b_reg;
    logic [SW-1:0]         in_w_reg;
    logic [ECW-1:0]        edge_count_reg, k_reg;
    logic [NIW-1:0]        sweep_reg, child_reg;
    logic [HSW-1:0]        heap_size_reg;
    logic                  heap_over_reg, boost_reg, rxflag_reg;
    logic [HIW-1:0]        hi_reg;
    logic [HEW-1:0]        ent_reg, cur_reg, chl_reg;
    logic [SW-1:0]         ew_reg;
    logic [DIST_W:0]       cand_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [NODE_FW-1:0]    res_id_reg;
    logic [DIST_W-1:0]     res_dw_reg, res_db_reg;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [STATUS_W-1:0]   m_user_reg;

    logic [CMP_W-1:0]  nc_w, n_eff, a_w, b_w, src_w, ea_w, eb_w, cur_node_w;
    logic              a_ok, b_ok, src_ok, edges_full, add_ok, sweep_last;
    logic [NIW-1:0]    a_idx, src_idx, cur_node, e_child;
    logic [DIST_W-1:0] cur_d, ent_d, rd_d, chl_d, rx_dv;
    logic              cur_flag;
    logic [HIW-1:0]    hsz_w, pu_par, puc_par, l_idx, r_idx, pi;
    logic              pu_less, lless, lless2, rless, hit_a, hit_b, e_valid, improve;
    logic [NODE_FW-1:0] e_a, e_b;
    logic [SW-1:0]     e_w;
    logic [STATUS_W-1:0] dec_status;
    logic              out_free;

    logic              heap_we;
    logic [HAW-1:0]    heap_waddr, heap_raddr;
    logic [HEW-1:0]    heap_wdata;
    logic              dw_we, db_we;
    logic [NIW-1:0]    dist_waddr, dist_raddr;
    logic [DIST_W-1:0] dist_wdata;
    logic              mark_we, mark_wdata;
    logic [NIW-1:0]    mark_waddr, mark_raddr;
    logic              edge_we;
    logic [EAW-1:0]    edge_raddr;

    assign nc_w       = CMP_W'(node_count_reg);
    assign n_eff      = (nc_w > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : nc_w;
    assign a_w        = CMP_W'(in_a_reg);
    assign b_w        = CMP_W'(in_b_reg);
    assign src_w      = CMP_W'(source_reg);
    assign a_ok       = a_w < n_eff;
    assign b_ok       = b_w < n_eff;
    assign src_ok     = src_w < n_eff;
    assign a_idx      = a_w[NIW-1:0];
    assign src_idx    = src_w[NIW-1:0];
    assign edges_full = (edge_count_reg == ECW'(MAX_EDGES));
    assign add_ok     = a_ok && b_ok && !edges_full;
    assign sweep_last = (sweep_reg == NIW'(MAX_NODES - 1));

    assign cur_d    = cur_reg[HEW-1:NIW+1];
    assign cur_node = cur_reg[NIW:1];
    assign cur_flag = cur_reg[0];
    assign ent_d    = ent_reg[HEW-1:NIW+1];
    assign rd_d     = heap_rdata_reg[HEW-1:NIW+1];
    assign chl_d    = chl_reg[HEW-1:NIW+1];

    assign hsz_w   = HIW'(heap_size_reg);
    assign pu_par  = (hsz_w - 1'b1) >> 1;
    assign pi      = (hi_reg - 1'b1) >> 1;
    assign puc_par = (pi - 1'b1) >> 1;
    assign l_idx   = (hi_reg << 1) + HIW'(1);
    assign r_idx   = (hi_reg << 1) + HIW'(2);
    assign pu_less = ent_d < rd_d;
    assign lless   = rd_d < ent_d;
    assign lless2  = chl_d < ent_d;
    assign rless   = rd_d < (lless2 ? chl_d : ent_d);

    assign e_a        = edge_rdata_reg[NODE_FW-1:0];
    assign e_b        = edge_rdata_reg[2*NODE_FW-1:NODE_FW];
    assign e_w        = edge_rdata_reg[EW-1:2*NODE_FW];
    assign ea_w       = CMP_W'(e_a);
    assign eb_w       = CMP_W'(e_b);
    assign cur_node_w = CMP_W'(cur_node);
    assign e_valid    = (ea_w < n_eff) && (eb_w < n_eff);
    assign hit_a      = (ea_w == cur_node_w);
    assign hit_b      = (eb_w == cur_node_w);
    assign e_child    = hit_a ? eb_w[NIW-1:0] : ea_w[NIW-1:0];

    assign rx_dv   = rxflag_reg ? db_rdata_reg : dw_rdata_reg;
    assign improve = (cand_reg < {1'b0, INF}) && (cand_reg[DIST_W-1:0] < rx_dv);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        case (in_cmd_reg)
            CMD_ADD_EDGE: dec_status = !(a_ok && b_ok) ? STAT_RANGE :
                                       (edges_full ? STAT_EDGE_FULL : STAT_OK);
            CMD_MARK:     dec_status = a_ok ? STAT_OK : STAT_RANGE;
            CMD_RUN:      dec_status = src_ok ? STAT_OK : STAT_RANGE;
            CMD_READ:     dec_status = a_ok ? STAT_OK : STAT_RANGE;
            default:      dec_status = STAT_OK;
        endcase
    end

    assign stat.in_cmd     = in_cmd_reg;
    assign stat.a_ok       = a_ok;
    assign stat.src_ok     = src_ok;
    assign stat.sweep_last = sweep_last;
    assign stat.heap_full  = (heap_size_reg == HSW'(HEAP_DEPTH));
    assign stat.size_zero  = (heap_size_reg == '0);
    assign stat.size_one   = (heap_size_reg == HSW'(1));
    assign stat.pu_less    = pu_less;
    assign stat.p_zero     = (pi == '0);
    assign stat.l_in       = l_idx < hsz_w;
    assign stat.r_in       = r_idx < hsz_w;
    assign stat.sd_move    = (cmd.op == ST_SDL) ? lless : (lless2 || rless);
    assign stat.stale      = cur_d > (cur_flag ? db_rdata_reg : dw_rdata_reg);
    assign stat.k_done     = k_reg >= edge_count_reg;
    assign stat.edge_hit   = e_valid && (hit_a || hit_b);
    assign stat.boost      = boost_reg;
    assign stat.improve    = improve;
    assign stat.out_free   = out_free;

    always_comb begin
        heap_we    = 1'b0;
        heap_waddr = hi_reg[HAW-1:0];
        heap_wdata = ent_reg;
        heap_raddr = '0;
        dw_we      = 1'b0;
        db_we      = 1'b0;
        dist_waddr = sweep_reg;
        dist_wdata = INF;
        dist_raddr = cur_node;
        mark_we    = 1'b0;
        mark_waddr = sweep_reg;
        mark_wdata = 1'b0;
        mark_raddr = cur_node;
        edge_we    = 1'b0;
        edge_raddr = k_reg[EAW-1:0];
        case (cmd.op)
            ST_INIT, ST_CLR: begin
                dw_we   = 1'b1;
                db_we   = 1'b1;
                mark_we = 1'b1;
            end
            ST_RCLR: begin
                dw_we = 1'b1;
                db_we = 1'b1;
            end
            ST_DEC: begin
                edge_we    = (in_cmd_reg == CMD_ADD_EDGE) && add_ok;
                mark_we    = (in_cmd_reg == CMD_MARK) && a_ok;
                mark_waddr = a_idx;
                mark_wdata = 1'b1;
                dist_raddr = a_idx;
            end
            ST_RSRD: mark_raddr = src_idx;
            ST_RSSET: begin
                dw_we      = !mark_rdata_reg;
                db_we      = mark_rdata_reg;
                dist_waddr = src_idx;
                dist_wdata = '0;
            end
            ST_PUS: begin
                heap_raddr = pu_par[HAW-1:0];
                heap_waddr = '0;
                heap_we    = !stat.heap_full && stat.size_zero;
            end
            ST_PUC: begin
                heap_we    = 1'b1;
                heap_raddr = puc_par[HAW-1:0];
                if (pu_less) heap_wdata = heap_rdata_reg;
            end
            ST_PUF: heap_we = 1'b1;
            ST_POPT: heap_raddr = HAW'(heap_size_reg - 1'b1);
            ST_SDS: begin
                heap_raddr = l_idx[HAW-1:0];
                heap_we    = !stat.l_in;
            end
            ST_SDL: begin
                heap_raddr = r_idx[HAW-1:0];
                heap_we    = !stat.r_in;
                if (lless) heap_wdata = heap_rdata_reg;
            end
            ST_SDR: begin
                heap_we = 1'b1;
                if (rless) heap_wdata = heap_rdata_reg;
                else if (lless2) heap_wdata = chl_reg;
            end
            ST_RBRD, ST_RWRD: dist_raddr = child_reg;
            ST_RXC: begin
                dw_we      = improve && !rxflag_reg;
                db_we      = improve && rxflag_reg;
                dist_waddr = child_reg;
                dist_wdata = cand_reg[DIST_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (edge_we) edge_mem[edge_count_reg[EAW-1:0]] <= {in_w_reg, in_b_reg, in_a_reg};
        edge_rdata_reg <= edge_mem[edge_raddr];
        if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
        heap_rdata_reg <= heap_mem[heap_raddr];
        if (dw_we) dw_mem[dist_waddr] <= dist_wdata;
        if (db_we) db_mem[dist_waddr] <= dist_wdata;
        dw_rdata_reg <= dw_mem[dist_raddr];
        db_rdata_reg <= db_mem[dist_raddr];
        if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
        mark_rdata_reg <= mark_mem[mark_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CFG_DATA_W'(256);
            source_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NODE_COUNT:  node_count_reg <= cfg_data;
                REG_SOURCE_NODE: source_reg <= cfg_data[NODE_FW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_cmd_reg <= s_tuser;
            in_a_reg   <= s_tdata[NODE_FW-1:0];
            in_b_reg   <= s_tdata[2*NODE_FW-1:NODE_FW];
            in_w_reg   <= s_tdata[2*NODE_FW+SW-1:2*NODE_FW];
        end
        case (cmd.op)
            ST_DEC: begin
                res_id_reg     <= (in_cmd_reg == CMD_RUN) ? source_reg : in_a_reg;
                res_status_reg <= dec_status;
                res_dw_reg     <= INF;
                res_db_reg     <= INF;
            end
            ST_RDW: begin
                res_dw_reg <= dw_rdata_reg;
                res_db_reg <= db_rdata_reg;
            end
            ST_RSSET: ent_reg <= {{DIST_W{1'b0}}, src_idx, mark_rdata_reg};
            ST_PUS:   hi_reg <= hsz_w;
            ST_PUC:   if (pu_less) hi_reg <= pi;
            ST_POPC:  if (heap_size_reg == '0) begin
                res_status_reg <= heap_over_reg ? STAT_HEAP_OVF : STAT_OK;
            end
            ST_POPT:  cur_reg <= heap_rdata_reg;
            ST_POPL: begin
                ent_reg <= heap_rdata_reg;
                hi_reg  <= '0;
            end
            ST_SDL: begin
                chl_reg <= heap_rdata_reg;
                if (!stat.r_in && lless) hi_reg <= l_idx;
            end
            ST_SDR: begin
                if (rless) hi_reg <= r_idx;
                else if (lless2) hi_reg <= l_idx;
            end
            ST_PRCHK: boost_reg <= cur_flag || mark_rdata_reg;
            ST_EDCHK: begin
                child_reg <= e_child;
                ew_reg    <= e_w;
            end
            ST_RBRD: begin
                cand_reg   <= (DIST_W+1)'(cur_d) + (DIST_W+1)'(ew_reg >> 1);
                rxflag_reg <= 1'b1;
            end
            ST_RWRD: begin
                cand_reg   <= (DIST_W+1)'(cur_d) + (DIST_W+1)'(ew_reg);
                rxflag_reg <= cur_flag;
            end
            ST_RXC: if (improve) ent_reg <= {cand_reg[DIST_W-1:0], child_reg, rxflag_reg};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_count_reg <= '0;
            sweep_reg      <= '0;
            heap_size_reg  <= '0;
            heap_over_reg  <= 1'b0;
            k_reg          <= '0;
        end else begin
            case (cmd.op)
                ST_INIT, ST_CLR, ST_RCLR: sweep_reg <= sweep_last ? '0 : sweep_reg + 1'b1;
                ST_DEC: begin
                    if (in_cmd_reg == CMD_CLEAR) edge_count_reg <= '0;
                    else if ((in_cmd_reg == CMD_ADD_EDGE) && add_ok) begin
                        edge_count_reg <= edge_count_reg + 1'b1;
                    end
                end
                ST_RSSET: begin
                    heap_size_reg <= '0;
                    heap_over_reg <= 1'b0;
                end
                ST_PUS: begin
                    if (stat.heap_full) heap_over_reg <= 1'b1;
                    else heap_size_reg <= heap_size_reg + 1'b1;
                end
                ST_POPT:  heap_size_reg <= heap_size_reg - 1'b1;
                ST_PRCHK: k_reg <= '0;
                ST_EDGE:  if (!stat.k_done) k_reg <= k_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((cmd.op == ST_RESP) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((cmd.op == ST_RESP) && out_free) begin
            m_data_reg <= {res_db_reg, res_dw_reg, res_id_reg};
            m_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hdl/two_layer_shortest_path_engine.sv =====
// Top level of the two-layer shortest-path engine: sequencer plus datapath.
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tuser = cmd, s_tdata = node_a, node_b, weight
//  m_        out        m_tvalid/m_tready  m_tuser = status, m_tdata = node_id, dists
//  cfg_      in         cfg_wr_en          cfg_index, cfg_data
//
// Add edge and mark go from decode to the response; read adds a distance-read step between them.
// Clear and run first sweep the distance stores, one node a cycle.
// A run then sifts down the heap for each popped entry, scans every stored edge
// for each popped entry that is not stale, and sifts up the heap for each push.
// After reset the same sweep clears distances and marks before the first
// request is taken. The result register lets the next request enter while a
// result waits on m_tready.
`timescale 1ns / 1ps
module two_layer_shortest_path_engine #(
    parameter int MAX_NODES   = tlsp_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES   = tlsp_pkg::DEF_MAX_EDGES,
    parameter int HEAP_DEPTH  = tlsp_pkg::DEF_HEAP_DEPTH,
    parameter int WEIGHT_BITS = tlsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // node_a [7:0], node_b [15:8], weight [35:16], zero [39:36]
    input  logic [tlsp_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd [2:0]
    input  logic [tlsp_pkg::CMD_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // node_id [7:0], dist_walk [47:8], dist_boosted [87:48]
    output logic [tlsp_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status [1:0]
    output logic [tlsp_pkg::STATUS_W-1:0]      m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [tlsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tlsp_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t stat;

    tlsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tlsp_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .HEAP_DEPTH  (HEAP_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the two-layer shortest-path engine with a scoreboard class.
`timescale 1ns / 1ps
module tb_top;
    import tlsp_pkg::*;

    localparam int NODES = DEF_MAX_NODES;
    localparam int EDGES = DEF_MAX_EDGES;
    localparam int HEAPN = DEF_HEAP_DEPTH;
    localparam logic [DIST_W-1:0] UNREACHED = {DIST_W{1'b1}};
    localparam int CYCLE_LIMIT = 20000000;
    localparam int SETTLE = NODES + 64;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_FW-1:0]  node_id;
        logic [DIST_W-1:0]   walk;
        logic [DIST_W-1:0]   boosted;
    } answer_t;

    typedef struct {
        logic [DIST_W-1:0]  d;
        logic [NODE_FW-1:0] node;
        logic               flag;
    } frontier_t;

    class path_scoreboard;
        logic [CFG_DATA_W-1:0] node_count = 9'd256;
        logic [NODE_FW-1:0]    source = 8'd0;
        logic [NODE_FW-1:0]    ea [EDGES];
        logic [NODE_FW-1:0]    eb [EDGES];
        logic [WEIGHT_FW-1:0]  ew [EDGES];
        int                    edge_total = 0;
        bit                    marks [NODES];
        logic [DIST_W-1:0]     walk_d [NODES];
        logic [DIST_W-1:0]     boost_d [NODES];
        frontier_t             heap [HEAPN];
        int                    heap_len;
        bit                    overflow;
        answer_t               awaited [$];
        int                    errors = 0;

        function new();
            wipe_dists();
            foreach (marks[i]) marks[i] = 0;
        endfunction

        function void wipe_dists();
            foreach (walk_d[i]) begin
                walk_d[i] = UNREACHED;
                boost_d[i] = UNREACHED;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_NODE_COUNT) node_count = val;
            else source = val[NODE_FW-1:0];
        endfunction

        function void push(logic [DIST_W-1:0] d, int node, bit flag);
            int i;
            frontier_t t;
            if (heap_len >= HEAPN) begin
                overflow = 1;
                return;
            end
            i = heap_len++;
            heap[i].d = d;
            heap[i].node = NODE_FW'(node);
            heap[i].flag = flag;
            while (i > 0 && heap[i].d < heap[(i - 1) / 2].d) begin
                t = heap[i];
                heap[i] = heap[(i - 1) / 2];
                heap[(i - 1) / 2] = t;
                i = (i - 1) / 2;
            end
        endfunction

        function frontier_t pop();
            frontier_t top, t;
            int i, l, r, m;
            top = heap[0];
            i = 0;
            heap_len--;
            heap[0] = heap[heap_len];
            forever begin
                l = 2 * i + 1;
                r = l + 1;
                m = i;
                if (l < heap_len && heap[l].d < heap[m].d) m = l;
                if (r < heap_len && heap[r].d < heap[m].d) m = r;
                if (m == i) break;
                t = heap[i];
                heap[i] = heap[m];
                heap[m] = t;
                i = m;
            end
            return top;
        endfunction

        function void relax(int child, bit flag, logic [DIST_W:0] cand);
            if (cand < {1'b0, UNREACHED}) begin
                if (flag && cand < boost_d[child]) begin
                    boost_d[child] = cand[DIST_W-1:0];
                    push(cand[DIST_W-1:0], child, 1);
                end else if (!flag && cand < walk_d[child]) begin
                    walk_d[child] = cand[DIST_W-1:0];
                    push(cand[DIST_W-1:0], child, 0);
                end
            end
        endfunction

        function void search(int n, int s);
            frontier_t e;
            bit boost;
            int child;
            heap_len = 0;
            overflow = 0;
            if (marks[s]) boost_d[s] = '0;
            else walk_d[s] = '0;
            push('0, s, marks[s]);
            while (heap_len > 0) begin
                e = pop();
                if (e.d > (e.flag ? boost_d[e.node] : walk_d[e.node])) continue;
                boost = e.flag || marks[e.node];
                for (int k = 0; k < edge_total; k++) begin
                    if (ea[k] >= n || eb[k] >= n) continue;
                    if (ea[k] == e.node) child = eb[k];
                    else if (eb[k] == e.node) child = ea[k];
                    else continue;
                    if (boost) relax(child, 1, {1'b0, e.d} + (ew[k] >> 1));
                    relax(child, e.flag, {1'b0, e.d} + ew[k]);
                end
            end
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [NODE_FW-1:0] a,
                                   logic [NODE_FW-1:0] b, logic [WEIGHT_FW-1:0] w);
            int n;
            answer_t r;
            n = (node_count > NODES) ? NODES : node_count;
            r.status = STAT_OK;
            r.node_id = a;
            r.walk = UNREACHED;
            r.boosted = UNREACHED;
            case (cmd)
                CMD_ADD_EDGE: begin
                    if (a >= n || b >= n) r.status = STAT_RANGE;
                    else if (edge_total >= EDGES) r.status = STAT_EDGE_FULL;
                    else begin
                        ea[edge_total] = a;
                        eb[edge_total] = b;
                        ew[edge_total] = w;
                        edge_total++;
                    end
                end
                CMD_MARK: begin
                    if (a >= n) r.status = STAT_RANGE;
                    else marks[a] = 1;
                end
                CMD_RUN: begin
                    r.node_id = source;
                    wipe_dists();
                    if (source >= n) r.status = STAT_RANGE;
                    else begin
                        search(n, source);
                        if (overflow) r.status = STAT_HEAP_OVF;
                    end
                end
                CMD_READ: begin
                    if (a >= n) r.status = STAT_RANGE;
                    else begin
                        r.walk = walk_d[a];
                        r.boosted = boost_d[a];
                    end
                end
                CMD_CLEAR: begin
                    edge_total = 0;
                    foreach (marks[i]) marks[i] = 0;
                    wipe_dists();
                end
                default: return;
            endcase
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_result(answer_t got);
            answer_t x;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            x = awaited.pop_front();
            if (got.status !== x.status) begin
                $display("%0t: status expected %0d actual %0d", $time, x.status, got.status);
                errors++;
            end
            if (got.node_id !== x.node_id) begin
                $display("%0t: node_id expected %0d actual %0d", $time, x.node_id, got.node_id);
                errors++;
            end
            if (got.walk !== x.walk) begin
                $display("%0t: dist_walk expected %h actual %h", $time, x.walk, got.walk);
                errors++;
            end
            if (got.boosted !== x.boosted) begin
                $display("%0t: dist_boosted expected %h actual %h", $time, x.boosted,
                         got.boosted);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    path_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int cycles = 0;
    int n_now = 256;

    two_layer_shortest_path_engine dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("two_layer_shortest_path_engine regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tuser, m_tdata[7:0], m_tdata[47:8], m_tdata[87:48]});
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send(logic [CMD_W-1:0] cmd, logic [NODE_FW-1:0] a,
                        logic [NODE_FW-1:0] b, logic [WEIGHT_FW-1:0] w);
        int gap;
        gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {4'b0, w, b, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, a, b, w);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] count, logic [NODE_FW-1:0] src);
        drain();
        write_reg(REG_NODE_COUNT, count);
        write_reg(REG_SOURCE_NODE, {1'b0, src});
        cfg_wr_en <= 0;
        n_now = (count > NODES) ? NODES : count;
    endtask

    function automatic logic [NODE_FW-1:0] pick_node();
        if (n_now >= NODES) return NODE_FW'($urandom_range(NODES - 1));
        if (n_now == 0 || $urandom_range(9) == 0) return NODE_FW'($urandom_range(NODES - 1));
        return NODE_FW'($urandom_range(n_now - 1));
    endfunction

    function automatic logic [WEIGHT_FW-1:0] pick_weight();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return WEIGHT_FW'($urandom_range(1, 100));
            default: return WEIGHT_FW'($urandom);
        endcase
    endfunction

    initial begin
        int count;
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        send(CMD_CLEAR, 0, 0, 0);
        send(CMD_ADD_EDGE, 0, 255, '1);
        send(CMD_ADD_EDGE, 0, 1, 0);
        send(CMD_ADD_EDGE, 1, 2, 7);
        send(CMD_ADD_EDGE, 2, 255, 20'd3);
        send(CMD_MARK, 1, 0, 0);
        send(CMD_RUN, 0, 0, 0);
        send(CMD_READ, 0, 0, 0);
        send(CMD_READ, 1, 0, 0);
        send(CMD_READ, 2, 0, 0);
        send(CMD_READ, 255, 0, 0);
        send(3'd5, 0, 0, 0);
        send(3'd7, 255, 255, '1);
        configure(9'd3, 8'd5);
        send(CMD_ADD_EDGE, 0, 3, 1);
        send(CMD_MARK, 200, 0, 0);
        send(CMD_READ, 3, 0, 0);
        send(CMD_RUN, 0, 0, 0);
        configure(9'd0, 8'd0);
        send(CMD_RUN, 0, 0, 0);
        send(CMD_ADD_EDGE, 0, 0, 1);
        configure(9'd511, 8'd255);
        send(CMD_RUN, 0, 0, 0);

        // Load many parallel edges and self-loops on a two-node graph, then run and read back.
        configure(9'd2, 8'd0);
        send_idle = 0;
        send(CMD_CLEAR, 0, 0, 0);
        send(CMD_MARK, 0, 0, 0);
        for (int k = 0; k < 40; k++) send(CMD_ADD_EDGE, NODE_FW'(k % 2), 1, pick_weight());
        send(CMD_RUN, 0, 0, 0);
        send(CMD_READ, 1, 0, 0);
        send(CMD_CLEAR, 0, 0, 0);

        for (int seq = 0; seq < 18; seq++) begin
            if (seq < 6) begin
                send_idle = 30;
                recv_idle = 51;
            end else if (seq < 12) begin
                send_idle = 51;
                recv_idle = 30;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            case ($urandom_range(5))
                0: count = 1;
                1: count = 256;
                2: count = $urandom_range(257, 511);
                default: count = $urandom_range(2, 24);
            endcase
            configure(CFG_DATA_W'(count),
                      NODE_FW'(($urandom_range(7) == 0) ? $urandom_range(255)
                               : $urandom_range(((count > NODES) ? NODES : count) - 1)));
            if ($urandom_range(3) != 0) send(CMD_CLEAR, 0, 0, 0);
            repeat ($urandom_range(4, 30)) begin
                if ($urandom_range(19) == 0) send(CMD_W'($urandom_range(5, 7)),
                                                  NODE_FW'($urandom), NODE_FW'($urandom),
                                                  WEIGHT_FW'($urandom));
                else send(CMD_ADD_EDGE, pick_node(), pick_node(), pick_weight());
            end
            repeat ($urandom_range(0, 3)) send(CMD_MARK, pick_node(), 0, 0);
            send(CMD_RUN, 0, 0, 0);
            repeat ($urandom_range(3, 8)) send(CMD_READ, pick_node(), 0, 0);
        end

        drain();
        if (sb.errors == 0) $display("two_layer_shortest_path_engine regression: pass");
        else $display("two_layer_shortest_path_engine regression: fail");
        $finish;
    end
endmodule
